// ===== hw/rtl/sus_pkg.sv =====
// shared types and constants for the sorted unique set with drain
package sus_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_DUP      = 3'd1,
        ST_ZERO     = 3'd2,
        ST_FULL     = 3'd3,
        ST_DRAINED  = 3'd4,
        ST_EMPTY    = 3'd5
    } status_t;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_DRAIN  = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        S_IDLE  = 1'b0,
        S_DRAIN = 1'b1
    } state_t;

    typedef struct packed {
        logic load_insert;
        logic load_empty;
        logic drain_step;
    } sus_cmd_t;

    typedef struct packed {
        logic empty;
        logic one_left;
    } sus_stat_t;

endpackage

// ===== hw/rtl/sus_ctrl.sv =====
// controller state machine for request acceptance and drain sequencing
module sus_ctrl
    import sus_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  logic      op,
    output logic      out_valid,
    input  logic      out_stall,
    input  sus_stat_t stat,
    output sus_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_load;

    assign can_load  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = !can_load;
                if (in_valid && can_load)
                begin
                    out_valid_next = 1'b1;
                    if (op == OP_INSERT)
                    begin
                        cmd.load_insert = 1'b1;
                    end
                    else if (stat.empty)
                    begin
                        cmd.load_empty = 1'b1;
                    end
                    else
                    begin
                        cmd.drain_step = 1'b1;
                        if (!stat.one_left)
                        begin
                            state_next = S_DRAIN;
                        end
                    end
                end
            end
            S_DRAIN:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    cmd.drain_step = 1'b1;
                    if (stat.one_left)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // drain state never sees an empty store
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRAIN |-> !stat.empty)
        else $error("drain state with empty store");

    // a held result is not overwritten by a new command
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> (cmd == '0))
        else $error("result overwritten while stalled");

    // final drain step returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.drain_step && stat.one_left) |=> state_reg == S_IDLE)
        else $error("drain did not finish");

endmodule

// ===== hw/rtl/sus_dp.sv =====
// datapath: sorted entry cells, compare logic and result register
module sus_dp
    import sus_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic signed [VAL_W-1:0] value,
    input  sus_cmd_t                cmd,
    output sus_stat_t               stat,
    output logic [2:0]              status,
    output logic signed [VAL_W-1:0] out_value,
    output logic                    last
);

    logic signed [VAL_W-1:0] entry_reg [CAPACITY];
    logic signed [VAL_W-1:0] entry_ins [CAPACITY];
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CAPACITY-1:0]     valid, keep, match;
    status_t                 ins_status;
    status_t                 status_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic                    last_reg;

    // per-cell compare against the incoming value
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            valid[i] = CNT_W'(i) < count_reg;
            keep[i]  = valid[i] && (entry_reg[i] < value);
            match[i] = valid[i] && (entry_reg[i] == value);
        end
        if (keep[0])
        begin
            entry_ins[0] = entry_reg[0];
        end
        else
        begin
            entry_ins[0] = value;
        end
        for (int i = 1; i < CAPACITY; i++)
        begin
            if (keep[i])
            begin
                entry_ins[i] = entry_reg[i];
            end
            else if (keep[i-1])
            begin
                entry_ins[i] = value;
            end
            else
            begin
                entry_ins[i] = entry_reg[i-1];
            end
        end
    end

    always_comb
    begin
        if (value == '0)
        begin
            ins_status = ST_ZERO;
        end
        else if (|match)
        begin
            ins_status = ST_DUP;
        end
        else if (count_reg == CNT_W'(CAPACITY))
        begin
            ins_status = ST_FULL;
        end
        else
        begin
            ins_status = ST_INSERTED;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.load_insert && ins_status == ST_INSERTED)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.drain_step)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_insert && ins_status == ST_INSERTED)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                entry_reg[i] <= entry_ins[i];
            end
        end
        else if (cmd.drain_step)
        begin
            for (int i = 0; i < CAPACITY - 1; i++)
            begin
                entry_reg[i] <= entry_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_insert)
        begin
            status_reg    <= ins_status;
            out_value_reg <= '0;
            last_reg      <= 1'b1;
        end
        else if (cmd.load_empty)
        begin
            status_reg    <= ST_EMPTY;
            out_value_reg <= '0;
            last_reg      <= 1'b1;
        end
        else if (cmd.drain_step)
        begin
            status_reg    <= ST_DRAINED;
            out_value_reg <= entry_reg[0];
            last_reg      <= stat.one_left;
        end
    end

    assign stat.empty    = count_reg == '0;
    assign stat.one_left = count_reg == CNT_W'(1);
    assign status        = status_reg;
    assign out_value     = out_value_reg;
    assign last          = last_reg;

    // fill count stays within capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // accepted insert grows the store by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_insert && ins_status == ST_INSERTED) |=>
        count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow store");

    // no insert lands when the store is full
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_insert && count_reg == CNT_W'(CAPACITY)) |=> $stable(count_reg))
        else $error("insert into full store");

endmodule

// ===== hw/rtl/sorted_unique_set_with_drain_unit.sv =====
// insert: one request per cycle if not stalled; result registered, valid next cycle
// drain of n stored values: n results, one per unstalled cycle, request taken in the first
// drain holds off new requests until its last value is loaded into the result register
// throughput is set by the single result register and the shifting entry cells
// reset clears the entry count, controller state and result valid; entry cells are not reset
module sorted_unique_set_with_drain_unit
    import sus_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    op,
    input  logic signed [VAL_W-1:0] value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [2:0]              status,
    output logic signed [VAL_W-1:0] out_value,
    output logic                    last
);

    sus_cmd_t  cmd;
    sus_stat_t stat;

    sus_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    sus_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .stat      (stat),
        .status    (status),
        .out_value (out_value),
        .last      (last)
    );

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the sorted unique set with drain
`timescale 1ns / 100ps

module testbench;
    import sus_pkg::*;

    localparam int REQUEST_TARGET = 350;
    localparam int CYCLE_LIMIT    = 200000;

    typedef struct {
        op_t                    op;
        logic signed [VAL_W-1:0] value;
        bit                     hold;
    } request_t;

    typedef struct {
        status_t                status;
        logic signed [VAL_W-1:0] value;
        logic                   last;
    } outcome_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    op = OP_INSERT;
    logic signed [VAL_W-1:0] value = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [2:0]              status;
    logic signed [VAL_W-1:0] out_value;
    logic                    last;

    request_t                request_q[$];
    outcome_t                awaited[$];
    logic signed [VAL_W-1:0] set_entries [CAPACITY];
    int                      set_count = 0;
    int                      gap_left = 0;
    int                      stall_left = 0;
    bit                      quiet_in = 1'b0;
    bit                      quiet_out = 1'b0;
    int                      mismatch_count = 0;
    int                      cycle_count = 0;

    sorted_unique_set_with_drain_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .out_value (out_value),
        .last      (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    function void apply_to_set(input op_t req_op, input logic signed [VAL_W-1:0] req_value);
        int      pos;
        status_t st;
        if (req_op == OP_DRAIN)
        begin
            if (set_count == 0)
                awaited.push_back('{ST_EMPTY, '0, 1'b1});
            else
            begin
                for (int i = 0; i < set_count; i++)
                    awaited.push_back('{ST_DRAINED, set_entries[i], i == set_count - 1});
                set_count = 0;
            end
        end
        else
        begin
            st = ST_INSERTED;
            if (req_value == 0)
                st = ST_ZERO;
            else
            begin
                for (int i = 0; i < set_count; i++)
                    if (set_entries[i] == req_value)
                        st = ST_DUP;
                if (st == ST_INSERTED && set_count >= CAPACITY)
                    st = ST_FULL;
            end
            if (st == ST_INSERTED)
            begin
                pos = 0;
                while (pos < set_count && set_entries[pos] < req_value)
                    pos++;
                for (int i = set_count; i > pos; i--)
                    set_entries[i] = set_entries[i - 1];
                set_entries[pos] = req_value;
                set_count++;
            end
            awaited.push_back('{st, '0, 1'b1});
        end
    endfunction

    function void add_request(input op_t req_op, input logic signed [VAL_W-1:0] req_value,
                              input bit hold);
        request_t r;
        r.op    = req_op;
        r.value = req_value;
        r.hold  = hold;
        request_q.push_back(r);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        request_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op       <= OP_INSERT;
            value    <= '0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                apply_to_set(op_t'(op), value);
                gap_left = quiet_in ? 0 : $urandom_range(0, 11);
                if ($urandom_range(0, 39) == 0)
                    quiet_in = !quiet_in;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (request_q.size() != 0 && !(request_q[0].hold && awaited.size() != 0))
                begin
                    nxt = request_q.pop_front();
                    op       <= nxt.op;
                    value    <= nxt.value;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : check_results
        outcome_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited.size() == 0)
                begin
                    $error("unexpected result: status %0d out_value %0d last %0d",
                           status, out_value, last);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        mismatch_count++;
                    end
                    if (out_value !== want.value)
                    begin
                        $error("out_value: expected %0d, got %0d", want.value, out_value);
                        mismatch_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        mismatch_count++;
                    end
                end
                stall_left = quiet_out ? 0 : $urandom_range(0, 11);
                if ($urandom_range(0, 39) == 0)
                    quiet_out = !quiet_out;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : stimulus
        int v;
        int burst;
        int sel;

        // drain of an empty store, value ignored
        add_request(OP_DRAIN, 32'h5a5a5a5a, 1'b0);
        add_request(OP_INSERT, 0, 1'b0);
        // fill to capacity, extremes included
        add_request(OP_INSERT, 32'h7fffffff, 1'b0);
        add_request(OP_INSERT, 32'h80000000, 1'b0);
        add_request(OP_INSERT, -1, 1'b0);
        add_request(OP_INSERT, 1, 1'b0);
        for (int k = 1; k <= 12; k++)
            add_request(OP_INSERT, (k % 2) ? k * 1000 : -k * 1000, 1'b0);
        // duplicate while full, new value while full, zero while full
        add_request(OP_INSERT, 32'h7fffffff, 1'b0);
        add_request(OP_INSERT, 2, 1'b0);
        add_request(OP_INSERT, 0, 1'b0);
        add_request(OP_DRAIN, 32'ha5a5a5a5, 1'b0);
        add_request(OP_DRAIN, 32'hffffffff, 1'b1);
        add_request(OP_INSERT, -5, 1'b0);
        add_request(OP_DRAIN, 32'h00000000, 1'b0);

        // random bursts of inserts closed by a drain
        while (request_q.size() < REQUEST_TARGET)
        begin
            burst = $urandom_range(0, 24);
            for (int i = 0; i < burst; i++)
            begin
                sel = $urandom_range(0, 9);
                if (sel == 0)
                    v = 0;
                else if (sel < 6)
                    v = int'($urandom_range(0, 40)) - 20;
                else
                    v = $urandom;
                add_request(OP_INSERT, v, $urandom_range(0, 59) == 0);
            end
            add_request(OP_DRAIN, $urandom, $urandom_range(0, 7) == 0);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (request_q.size() != 0 || in_valid || awaited.size() != 0);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
